>>> rtl/sprite_entry_quad_expander_unit_macros.svh
// assertion macros for the sprite entry quad expander
`ifndef SPRITE_ENTRY_QUAD_EXPANDER_UNIT_MACROS_SVH
`define SPRITE_ENTRY_QUAD_EXPANDER_UNIT_MACROS_SVH

// same-cycle implication
`define SEQX_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SEQX_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/seqx_pkg.sv
// shared types and constants of the sprite entry quad expander
package seqx_pkg;

	localparam int MAX_QUADS  = 4096;
	localparam int LINK_WORDS = 2048;
	localparam int CLIP_WORDS = 16;

	localparam int LINK_AW  = $clog2(LINK_WORDS);
	localparam int CLIP_AW  = $clog2(CLIP_WORDS);
	localparam int COUNT_W  = 13;
	localparam int COORD_W  = 23;
	localparam int TILE_W   = 17;

	// remainder unit: bits retired per cycle and steps per tile
	localparam int DIV_BITS  = 4;
	localparam int DIV_STEPS = (TILE_W + DIV_BITS - 1) / DIV_BITS;
	localparam int DIV_NUM_W = DIV_STEPS * DIV_BITS;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [7:0] LINK_SEQUENTIAL = 8'hff;
	localparam logic [7:0] CUE_MODE_CODE  = 8'hfe;
	localparam int CLIP_MAX_X = 639;
	localparam int CLIP_MAX_Y = 479;

	typedef enum logic [1:0] {
		KIND_SPRITE = 2'd0,
		KIND_CLIP   = 2'd1,
		KIND_LINK   = 2'd2,
		KIND_FRAME  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		REG_OFFSET_X   = 2'd0,
		REG_OFFSET_Y   = 2'd1,
		REG_Y_HALF_RES = 2'd2,
		REG_TILE_COUNT = 2'd3
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLIPA,
		ST_CLIPB,
		ST_TILE,
		ST_LINK,
		ST_DIV,
		ST_EMIT
	} state_t;

endpackage

>>> rtl/seqx_ram.sv
// generic single-write, single-read RAM with registered read data
module seqx_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/seqx_mod_unit.sv
// multi-cycle remainder unit, DIV_BITS quotient bits per cycle
module seqx_mod_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [seqx_pkg::TILE_W-1:0] dividend,
	input  logic [seqx_pkg::TILE_W-1:0] divisor,
	output logic                       done,
	output logic [seqx_pkg::TILE_W-1:0] remainder
);

	logic [seqx_pkg::DIV_NUM_W-1:0] num_q, num_nxt;
	logic [seqx_pkg::TILE_W:0]      rem_q, rem_nxt, trial;
	logic [seqx_pkg::TILE_W-1:0]    div_q;
	logic [seqx_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           run_q, done_q;

	// restoring steps of this cycle
	always_comb begin
		rem_nxt = rem_q;
		num_nxt = num_q;
		trial   = '0;
		for (int i = 0; i < seqx_pkg::DIV_BITS; i++) begin
			trial   = {rem_nxt[seqx_pkg::TILE_W-1:0], num_nxt[seqx_pkg::DIV_NUM_W-1]};
			num_nxt = num_nxt << 1;
			if (trial >= {1'b0, div_q}) begin
				trial = trial - {1'b0, div_q};
			end
			rem_nxt = trial;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == seqx_pkg::DIV_CNT_W'(seqx_pkg::DIV_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= seqx_pkg::DIV_NUM_W'(dividend);
			rem_q <= '0;
			div_q <= divisor;
		end else if (run_q) begin
			num_q <= num_nxt;
			rem_q <= rem_nxt;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q[seqx_pkg::TILE_W-1:0];

endmodule

>>> rtl/sprite_entry_quad_expander_unit.sv
// top level of the sprite entry quad expander
//
// channel | dir | handshake          | contents
// in      | in  | in_valid/in_ready  | kind, six sprite words, table address and data
// out     | out | out_valid/out_ready| one quad with clip, tile, depth, attributes, last
// cfg     | in  | cfg_valid/cfg_ready| register index and data, always ready
//
// a table write or frame start is taken in the idle state; a sprite runs a clip read
// and setup (CLIPA, CLIPB), then per quad a tile step (TILE), a link read (LINK),
// the remainder steps and their result (DIV) and the output state (EMIT);
// the remainder unit sets the quad rate
// reset loads config defaults, clears the quad count and sequencer, not the tables
// an output stall holds the sequencer; no new item is taken until the sprite is done
`include "sprite_entry_quad_expander_unit_macros.svh"

module sprite_entry_quad_expander_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [31:0] position_word,
	input  logic [31:0] size_word,
	input  logic [31:0] control_word,
	input  logic [31:0] tile_word,
	input  logic [31:0] depth_word,
	input  logic [31:0] color_word,
	input  logic [10:0] table_address,
	input  logic [31:0] table_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [22:0] quad_left,
	output logic signed [22:0] quad_right,
	output logic signed [22:0] quad_top,
	output logic signed [22:0] quad_bottom,
	output logic [14:0] bound_left,
	output logic signed [18:0] bound_right,
	output logic [14:0] bound_top,
	output logic signed [17:0] bound_bottom,
	output logic [15:0] tile_index,
	output logic [23:0] sort_depth,
	output logic [18:0] attributes,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [17:0] cfg_data
);

	localparam int CW = seqx_pkg::COORD_W;

	seqx_pkg::state_t state_q, state_nxt;

	// configuration
	logic [17:0] offset_x_q;
	logic [16:0] offset_y_q;
	logic        y_half_res_q;
	logic [16:0] tile_count_q;
	logic [seqx_pkg::COUNT_W-1:0] quad_count_q;

	// latched sprite
	logic [31:0] pos_q, size_q, ctrl_q, tile_w_q, depth_q, color_q;

	// geometry
	logic signed [CW-1:0] x0_q, cur_x_q, cur_y_q, sx_q, sy_q;
	logic [2:0] col_q, row_q, cols_m1_q, rows_m1_q;
	logic [5:0] off_q;
	logic       zero_size_q;
	logic signed [19:0] cl_q, cr_q;
	logic signed [18:0] ct_q, cb_q;

	// output register
	logic signed [CW-1:0] qleft_q, qright_q, qtop_q, qbot_q;
	logic [15:0] tile_q;
	logic        last_q;

	// accept strobes
	logic in_acc, out_acc;
	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;
	assign cfg_ready = 1'b1;

	// table ports
	logic clip_we, link_we;
	logic [seqx_pkg::CLIP_AW-1:0] clip_raddr;
	logic [seqx_pkg::LINK_AW-1:0] link_raddr;
	logic [31:0] clip_rdata;
	logic [15:0] link_rdata;

	assign clip_we = in_acc && (kind == seqx_pkg::KIND_CLIP)
		&& (32'(table_address) < 32'(seqx_pkg::CLIP_WORDS));
	assign link_we = in_acc && (kind == seqx_pkg::KIND_LINK)
		&& (32'(table_address) < 32'(seqx_pkg::LINK_WORDS));

	seqx_ram #(.WIDTH(32), .DEPTH(seqx_pkg::CLIP_WORDS)) u_clip_ram (
		.clk   (clk),
		.we    (clip_we),
		.waddr (table_address[seqx_pkg::CLIP_AW-1:0]),
		.wdata (table_data),
		.raddr (clip_raddr),
		.rdata (clip_rdata)
	);

	seqx_ram #(.WIDTH(16), .DEPTH(seqx_pkg::LINK_WORDS)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (seqx_pkg::LINK_AW'(table_address)),
		.wdata (table_data[15:0]),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	// clip select: even entry from the input on accept, odd entry after
	logic [3:0] sel_in, sel_q;
	assign sel_in = {control_word[26:24], 1'b0};
	assign sel_q  = {ctrl_q[26:24], 1'b0};
	assign clip_raddr = (state_q == seqx_pkg::ST_IDLE) ? seqx_pkg::CLIP_AW'(sel_in)
		: seqx_pkg::CLIP_AW'({sel_q[3:1], 1'b1});

	// link address for the current tile
	logic [7:0]  link_sel;
	logic [11:0] link_idx;
	logic        link_in_range;
	assign link_sel      = ctrl_q[23:16];
	assign link_idx      = {2'b0, link_sel, 2'b0} + 12'(off_q);
	assign link_in_range = 32'(link_idx) < 32'(seqx_pkg::LINK_WORDS);
	assign link_raddr    = seqx_pkg::LINK_AW'(link_idx);

	// sprite geometry from latched words
	logic [3:0] cols_n, rows_n;
	logic [15:0] sx16, sy16;
	logic flip_x, flip_y;
	logic [CW-1:0] span_x, span_y, gx, gy, gsx, gsy;
	always_comb begin
		cols_n = (ctrl_q[6:4] == 3'd0) ? 4'd8 : {1'b0, ctrl_q[6:4]};
		rows_n = (ctrl_q[2:0] == 3'd0) ? 4'd8 : {1'b0, ctrl_q[2:0]};
		sx16   = size_q[31:16];
		sy16   = size_q[15:0];
		flip_x = ctrl_q[7];
		flip_y = ctrl_q[3];
		span_x = CW'(sx16 * cols_n) - CW'(1);
		span_y = CW'(sy16 * rows_n) - CW'(1);
		gx = CW'(pos_q[31:16]) - CW'(offset_x_q);
		gy = CW'(pos_q[15:0]) - CW'(offset_y_q);
		if (ctrl_q[9]) gx = gx - span_x;
		if (ctrl_q[8]) gy = gy - span_y;
		if (flip_y) gy = gy + span_y;
		if (flip_x) gx = gx + span_x;
		gsx = flip_x ? -CW'(sx16) : CW'(sx16);
		gsy = flip_y ? -CW'(sy16) : CW'(sy16);
		if (y_half_res_q) begin
			gsy = gsy << 1;
			gy  = gy << 1;
		end
	end

	// clip bounds from the table word, moved and clamped
	logic signed [19:0] cx_lo, cx_hi;
	logic signed [18:0] cy_lo, cy_hi;
	always_comb begin
		cx_lo = 20'($signed(clip_rdata[31:16])) - $signed({2'b0, offset_x_q});
		cx_hi = 20'($signed(clip_rdata[15:0])) - $signed({2'b0, offset_x_q});
		cy_lo = 19'($signed(clip_rdata[31:16])) - $signed({2'b0, offset_y_q});
		cy_hi = 19'($signed(clip_rdata[15:0])) - $signed({2'b0, offset_y_q});
		if (cx_lo < 0) cx_lo = '0;
		if (cx_hi > 20'sd639) cx_hi = 20'(seqx_pkg::CLIP_MAX_X);
		if (cy_lo < 0) cy_lo = '0;
		if (cy_hi > 19'sd479) cy_hi = 19'(seqx_pkg::CLIP_MAX_Y);
	end

	logic drop;
	assign drop = zero_size_q || (cl_q > cr_q) || (cy_lo > cy_hi);

	// tile number before the modulo
	logic [16:0] tile_sum;
	always_comb begin
		if (link_sel == seqx_pkg::LINK_SEQUENTIAL) begin
			tile_sum = 17'(tile_w_q[31:16]) + 17'(off_q);
		end else if (link_in_range) begin
			tile_sum = 17'(tile_w_q[31:16]) + 17'(link_rdata);
		end else begin
			tile_sum = 17'(tile_w_q[31:16]);
		end
	end

	logic div_start, div_done;
	logic [seqx_pkg::TILE_W-1:0] div_rem;

	seqx_mod_unit u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (tile_sum),
		.divisor   (tile_count_q),
		.done      (div_done),
		.remainder (div_rem)
	);

	// end of sprite for the quad being built
	logic limit_hit, final_tile, quad_last;
	assign limit_hit  = 32'(quad_count_q) >= 32'(seqx_pkg::MAX_QUADS);
	assign final_tile = (col_q == cols_m1_q) && (row_q == rows_m1_q);
	assign quad_last  = final_tile
		|| (32'(quad_count_q) + 32'd1 >= 32'(seqx_pkg::MAX_QUADS));

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			seqx_pkg::ST_IDLE: begin
				if (in_acc && kind == seqx_pkg::KIND_SPRITE && tile_count_q != '0) begin
					state_nxt = seqx_pkg::ST_CLIPA;
				end
			end
			seqx_pkg::ST_CLIPA: state_nxt = seqx_pkg::ST_CLIPB;
			seqx_pkg::ST_CLIPB: state_nxt = drop ? seqx_pkg::ST_IDLE : seqx_pkg::ST_TILE;
			seqx_pkg::ST_TILE: state_nxt = limit_hit ? seqx_pkg::ST_IDLE : seqx_pkg::ST_LINK;
			seqx_pkg::ST_LINK: state_nxt = seqx_pkg::ST_DIV;
			seqx_pkg::ST_DIV: begin
				if (div_done) state_nxt = seqx_pkg::ST_EMIT;
			end
			seqx_pkg::ST_EMIT: begin
				if (out_ready) begin
					state_nxt = last_q ? seqx_pkg::ST_IDLE : seqx_pkg::ST_TILE;
				end
			end
			default: state_nxt = seqx_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			seqx_pkg::ST_IDLE: in_ready  = 1'b1;
			seqx_pkg::ST_LINK: div_start = 1'b1;
			seqx_pkg::ST_EMIT: out_valid = 1'b1;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= seqx_pkg::ST_IDLE;
			offset_x_q   <= 18'd45;
			offset_y_q   <= 17'd42;
			y_half_res_q <= 1'b0;
			tile_count_q <= 17'd1;
			quad_count_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (cfg_valid) begin
				unique case (seqx_pkg::reg_index_t'(cfg_index))
					seqx_pkg::REG_OFFSET_X:   offset_x_q   <= cfg_data;
					seqx_pkg::REG_OFFSET_Y:   offset_y_q   <= cfg_data[16:0];
					seqx_pkg::REG_Y_HALF_RES: y_half_res_q <= cfg_data[0];
					seqx_pkg::REG_TILE_COUNT: tile_count_q <= cfg_data[16:0];
					default: ;
				endcase
			end
			if (in_acc && kind == seqx_pkg::KIND_FRAME) begin
				quad_count_q <= '0;
			end else if (out_acc) begin
				quad_count_q <= quad_count_q + 1'b1;
			end
		end
	end

	// sprite datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pos_q    <= position_word;
			size_q   <= size_word;
			ctrl_q   <= control_word;
			tile_w_q <= tile_word;
			depth_q  <= depth_word;
			color_q  <= color_word;
		end
		if (state_q == seqx_pkg::ST_CLIPA) begin
			x0_q        <= gx;
			cur_x_q     <= gx;
			cur_y_q     <= gy;
			sx_q        <= gsx;
			sy_q        <= gsy;
			cols_m1_q   <= 3'(cols_n - 4'd1);
			rows_m1_q   <= 3'(rows_n - 4'd1);
			zero_size_q <= (sx16 == '0) || (sy16 == '0);
			col_q       <= '0;
			row_q       <= '0;
			off_q       <= '0;
			cl_q        <= cx_lo;
			cr_q        <= cx_hi;
		end
		if (state_q == seqx_pkg::ST_CLIPB) begin
			ct_q <= cy_lo;
			cb_q <= cy_hi;
		end
		// load the output register when the tile number is ready
		if (state_q == seqx_pkg::ST_DIV && div_done) begin
			qleft_q  <= ctrl_q[7] ? cur_x_q + sx_q : cur_x_q;
			qright_q <= ctrl_q[7] ? cur_x_q : cur_x_q + sx_q;
			qtop_q   <= ctrl_q[3] ? cur_y_q + sy_q : cur_y_q;
			qbot_q   <= ctrl_q[3] ? cur_y_q : cur_y_q + sy_q;
			tile_q   <= div_rem[15:0];
			last_q   <= quad_last;
		end
		// step to the next tile, row by row
		if (out_acc) begin
			off_q <= off_q + 1'b1;
			if (col_q == cols_m1_q) begin
				col_q   <= '0;
				row_q   <= row_q + 1'b1;
				cur_x_q <= x0_q;
				cur_y_q <= cur_y_q + sy_q;
			end else begin
				col_q   <= col_q + 1'b1;
				cur_x_q <= cur_x_q + sx_q;
			end
		end
	end

	assign quad_left    = qleft_q;
	assign quad_right   = qright_q;
	assign quad_top     = qtop_q;
	assign quad_bottom  = qbot_q;
	assign bound_left   = cl_q[14:0];
	assign bound_right  = cr_q[18:0];
	assign bound_top    = ct_q[14:0];
	assign bound_bottom = cb_q[17:0];
	assign tile_index   = tile_q;
	assign sort_depth   = depth_q[23:0];
	assign attributes   = {ctrl_q[3], ctrl_q[7],
		color_q[7:0] == seqx_pkg::CUE_MODE_CODE, tile_w_q[15:8], color_q[23:16]};
	assign last         = last_q;

	// checks
	`SEQX_ASSERT_NOW(a_count_bound, 1'b1,
		32'(quad_count_q) <= 32'(seqx_pkg::MAX_QUADS), "quad count beyond limit")
	`SEQX_ASSERT_NOW(a_one_item, out_valid, !in_ready, "input taken while a quad waits")
	`SEQX_ASSERT_NEXT(a_last_ends, out_acc && last, in_ready, "sprite not closed after last")
	`SEQX_ASSERT_NEXT(a_limit_last, out_acc && !last,
		32'(quad_count_q) < 32'(seqx_pkg::MAX_QUADS), "quad past limit without last")

endmodule
